/* sv/psf_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the packet framer
// no dependencies
package psf_pkg;

  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE    = 3'd4;

  localparam logic [BYTE_W-1:0] RST_SOURCE_ADDRESS = 8'd0;
  localparam logic [BYTE_W-1:0] RST_MAX_PAYLOAD    = 8'd32;
  localparam logic [CRC_W-1:0]  RST_CRC_POLYNOMIAL = 16'd4129;
  localparam logic [BYTE_W-1:0] RST_FLAG_BYTE      = 8'd126;
  localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE    = 8'd125;

  localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_PICK = 5'b00100,
    ST_CRC  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // position within a frame
  typedef enum logic [3:0] {
    EL_FLAG_OPEN,
    EL_FRAME_IDX,
    EL_LAST_IDX,
    EL_SRC,
    EL_DEST,
    EL_LEN,
    EL_DATA,
    EL_CRC_HI,
    EL_CRC_LO,
    EL_FLAG_CLOSE
  } elem_t;

  typedef enum logic {
    OP_CRC,
    OP_DIV
  } op_t;

endpackage

/* sv/packet_splitting_stuffing_framer.sv */
`timescale 1ns / 1ps
// Each header or payload byte is selected, then passed through one shared shift unit for
// the crc, then sent as one or two output beats; a frame opening adds the flag and five
// header bytes, a frame close adds two crc bytes and the flag. A first beat of a nonempty
// packet also runs a divide on the same unit. Not ready while a beat is in work.
// Synchronous active-low reset clears control state and loads register defaults.
module packet_splitting_stuffing_framer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [psf_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic [psf_pkg::BYTE_W-1:0]         in_packet_length,
  input  logic [psf_pkg::BYTE_W-1:0]         in_dest_address,
  input  logic                               in_first_of_packet,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [psf_pkg::BYTE_W-1:0]         out_line_byte,
  output logic                               out_frame_end,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import psf_pkg::*;

  // configuration
  logic [BYTE_W-1:0] src_addr_r, max_pl_r, flag_r, esc_r;
  logic [CRC_W-1:0]  poly_r;

  // control and datapath state
  state_t            state_r, state_nxt;
  elem_t             elem_r, elem_nxt;
  logic [CRC_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BYTE_W-1:0] pbl_r, pbl_nxt;
  logic [BYTE_W-1:0] fbl_r, fbl_nxt;
  logic [BYTE_W-1:0] fidx_r, fidx_nxt;
  logic [BYTE_W-1:0] lfi_r, lfi_nxt;
  logic [BYTE_W-1:0] dest_r, dest_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              esc_pend_r, esc_pend_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              oend_r, oend_nxt;
  logic              olast_r, olast_nxt;

  // shared shift unit: crc step or restoring divide step
  op_t               op;
  logic [CRC_W-1:0]  unit_out;
  logic [CRC_W-1:0]  shl;
  logic [BYTE_W:0]   rem_sh, rem_diff, divisor;
  logic              rem_ge;
  logic [BYTE_W-1:0] limit;

  assign limit   = (max_pl_r == '0) ? BYTE_W'(1) : max_pl_r;
  assign divisor = {1'b0, limit};
  assign shl     = {acc_r[CRC_W-2:0], 1'b0};
  // acc holds {remainder, quotient} while dividing
  assign rem_sh   = acc_r[CRC_W-1:BYTE_W-1];
  assign rem_diff = rem_sh - divisor;
  assign rem_ge   = (rem_sh >= divisor);

  always_comb begin
    unique case (op)
      OP_CRC: unit_out = acc_r[CRC_W-1] ? (shl ^ poly_r) : shl;
      OP_DIV: unit_out = {(rem_ge ? rem_diff[BYTE_W-1:0] : rem_sh[BYTE_W-1:0]),
                          acc_r[BYTE_W-2:0], rem_ge};
      default: unit_out = shl;
    endcase
  end

  assign op = (state_r == ST_DIV) ? OP_DIV : OP_CRC;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_line_byte   = obyte_r;
  assign out_frame_end   = oend_r;
  assign out_last_of_run = olast_r;

  // sequencer
  logic              stuff;
  logic [BYTE_W-1:0] fbl_dec;

  assign fbl_dec = fbl_r - BYTE_W'(1);

  always_comb begin
    state_nxt    = state_r;
    elem_nxt     = elem_r;
    acc_nxt      = acc_r;
    step_nxt     = step_r;
    pbl_nxt      = pbl_r;
    fbl_nxt      = fbl_r;
    fidx_nxt     = fidx_r;
    lfi_nxt      = lfi_r;
    dest_nxt     = dest_r;
    data_nxt     = data_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    esc_pend_nxt = esc_pend_r;
    obyte_nxt    = obyte_r;
    oend_nxt     = oend_r;
    olast_nxt    = olast_r;
    stuff        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = in_data_byte;
          if (in_first_of_packet) begin
            pbl_nxt  = in_packet_length;
            fbl_nxt  = '0;
            fidx_nxt = '0;
            dest_nxt = in_dest_address;
            step_nxt = '0;
            if (in_packet_length == '0) begin
              lfi_nxt = '0;
              acc_nxt = '0;
            end else begin
              acc_nxt   = {BYTE_W'(0), in_packet_length - BYTE_W'(1)};
              state_nxt = ST_DIV;
            end
          end else if (pbl_r != '0) begin
            elem_nxt  = (fbl_r == '0) ? EL_FLAG_OPEN : EL_DATA;
            state_nxt = ST_PICK;
          end
        end
      end

      ST_DIV: begin
        acc_nxt  = unit_out;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          lfi_nxt   = unit_out[BYTE_W-1:0];
          acc_nxt   = '0;
          elem_nxt  = EL_FLAG_OPEN;
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        step_nxt = '0;
        last_nxt = 1'b0;
        unique case (elem_r)
          EL_FLAG_OPEN: begin
            acc_nxt   = '0;
            obyte_nxt = flag_r;
            oend_nxt  = 1'b0;
            olast_nxt = 1'b0;
            esc_pend_nxt = 1'b0;
            state_nxt = ST_OUT;
          end
          EL_FRAME_IDX: byte_nxt = fidx_r;
          EL_LAST_IDX:  byte_nxt = lfi_r;
          EL_SRC:       byte_nxt = src_addr_r;
          EL_DEST:      byte_nxt = dest_r;
          EL_LEN: begin
            byte_nxt = (pbl_r < limit) ? pbl_r : limit;
            fbl_nxt  = byte_nxt;
          end
          EL_DATA: begin
            byte_nxt = data_r;
            fbl_nxt  = fbl_dec;
            pbl_nxt  = pbl_r - BYTE_W'(1);
            last_nxt = (fbl_dec != '0);
          end
          EL_CRC_HI: begin
            byte_nxt = acc_r[CRC_W-1:BYTE_W];
            stuff    = 1'b1;
          end
          EL_CRC_LO: begin
            byte_nxt = acc_r[BYTE_W-1:0];
            stuff    = 1'b1;
          end
          EL_FLAG_CLOSE: begin
            acc_nxt   = '0;
            fidx_nxt  = fidx_r + BYTE_W'(1);
            last_nxt  = 1'b1;
            obyte_nxt = flag_r;
            oend_nxt  = 1'b1;
            olast_nxt = 1'b1;
            esc_pend_nxt = 1'b0;
            state_nxt = ST_OUT;
          end
          default: state_nxt = ST_IDLE;
        endcase
        // header and payload bytes go through the crc first
        if (elem_r == EL_FRAME_IDX || elem_r == EL_LAST_IDX || elem_r == EL_SRC ||
            elem_r == EL_DEST || elem_r == EL_LEN || elem_r == EL_DATA) begin
          acc_nxt   = acc_r ^ {byte_nxt, BYTE_W'(0)};
          state_nxt = ST_CRC;
        end
      end

      ST_CRC: begin
        acc_nxt  = unit_out;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          stuff = 1'b1;
        end
      end

      ST_OUT: begin
        if (out_ready) begin
          if (esc_pend_r) begin
            obyte_nxt    = byte_r ^ ESC_XOR;
            olast_nxt    = last_r;
            esc_pend_nxt = 1'b0;
          end else if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PICK;
            unique case (elem_r)
              EL_FLAG_OPEN: elem_nxt = EL_FRAME_IDX;
              EL_FRAME_IDX: elem_nxt = EL_LAST_IDX;
              EL_LAST_IDX:  elem_nxt = EL_SRC;
              EL_SRC:       elem_nxt = EL_DEST;
              EL_DEST:      elem_nxt = EL_LEN;
              EL_LEN:       elem_nxt = EL_DATA;
              EL_DATA:      elem_nxt = EL_CRC_HI;
              EL_CRC_HI:    elem_nxt = EL_CRC_LO;
              EL_CRC_LO:    elem_nxt = EL_FLAG_CLOSE;
              EL_FLAG_CLOSE: state_nxt = ST_IDLE;
              default:      state_nxt = ST_IDLE;
            endcase
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // load the output beat, with escape where the byte clashes
    if (stuff) begin
      oend_nxt  = 1'b0;
      state_nxt = ST_OUT;
      if (byte_nxt == flag_r || byte_nxt == esc_r) begin
        obyte_nxt    = esc_r;
        olast_nxt    = 1'b0;
        esc_pend_nxt = 1'b1;
      end else begin
        obyte_nxt    = byte_nxt;
        olast_nxt    = last_nxt;
        esc_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      elem_r     <= EL_FLAG_OPEN;
      acc_r      <= '0;
      step_r     <= '0;
      pbl_r      <= '0;
      fbl_r      <= '0;
      fidx_r     <= '0;
      lfi_r      <= '0;
      dest_r     <= '0;
      last_r     <= 1'b0;
      esc_pend_r <= 1'b0;
      src_addr_r <= RST_SOURCE_ADDRESS;
      max_pl_r   <= RST_MAX_PAYLOAD;
      poly_r     <= RST_CRC_POLYNOMIAL;
      flag_r     <= RST_FLAG_BYTE;
      esc_r      <= RST_ESCAPE_BYTE;
    end else begin
      state_r    <= state_nxt;
      elem_r     <= elem_nxt;
      acc_r      <= acc_nxt;
      step_r     <= step_nxt;
      pbl_r      <= pbl_nxt;
      fbl_r      <= fbl_nxt;
      fidx_r     <= fidx_nxt;
      lfi_r      <= lfi_nxt;
      dest_r     <= dest_nxt;
      last_r     <= last_nxt;
      esc_pend_r <= esc_pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOURCE_ADDRESS: src_addr_r <= cfg_data[BYTE_W-1:0];
          CFG_MAX_PAYLOAD:    max_pl_r   <= cfg_data[BYTE_W-1:0];
          CFG_CRC_POLYNOMIAL: poly_r     <= cfg_data[CRC_W-1:0];
          CFG_FLAG_BYTE:      flag_r     <= cfg_data[BYTE_W-1:0];
          CFG_ESCAPE_BYTE:    esc_r      <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    byte_r  <= byte_nxt;
    obyte_r <= obyte_nxt;
    oend_r  <= oend_nxt;
    olast_r <= olast_nxt;
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for packet_splitting_stuffing_framer: directed and random packets
// against an in-bench frame predictor; depends on sv/psf_pkg.sv and the framer rtl
module tb_top;
  import psf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] plen;
    logic [BYTE_W-1:0] dest;
    logic              first;
  } pkt_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] line;
    logic              frame_end;
    logic              last;
  } line_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic [BYTE_W-1:0]     in_packet_length = '0;
  logic [BYTE_W-1:0]     in_dest_address = '0;
  logic                  in_first_of_packet = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_line_byte;
  logic                  out_frame_end;
  logic                  out_last_of_run;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  packet_splitting_stuffing_framer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_packet_length  (in_packet_length),
    .in_dest_address   (in_dest_address),
    .in_first_of_packet(in_first_of_packet),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_byte     (out_line_byte),
    .out_frame_end     (out_frame_end),
    .out_last_of_run   (out_last_of_run),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // register shadow
  logic [BYTE_W-1:0] reg_src  = RST_SOURCE_ADDRESS;
  logic [BYTE_W-1:0] reg_max  = RST_MAX_PAYLOAD;
  logic [CRC_W-1:0]  reg_poly = RST_CRC_POLYNOMIAL;
  logic [BYTE_W-1:0] reg_flag = RST_FLAG_BYTE;
  logic [BYTE_W-1:0] reg_esc  = RST_ESCAPE_BYTE;

  // framer state as the predictor sees it
  logic [CRC_W-1:0]  crc_acc   = '0;
  logic [BYTE_W-1:0] pkt_left  = '0;
  logic [BYTE_W-1:0] frm_left  = '0;
  logic [BYTE_W-1:0] frm_idx   = '0;
  logic [BYTE_W-1:0] last_idx  = '0;
  logic [BYTE_W-1:0] dest_hold = '0;

  pkt_beat_t  beat_q[$];
  line_beat_t line_exp_q[$];
  pkt_beat_t  drv_beat = '0;

  int   beats_queued = 0;
  int   beats_taken = 0;
  int   err_cnt = 0;
  int   long_stall_seq = 0;
  logic in_fired = 1'b0;
  logic out_fired = 1'b0;
  logic snd_idle_en = 1'b0;
  logic rcv_idle_en = 1'b0;

  function automatic logic [BYTE_W-1:0] eff_payload();
    return (reg_max == '0) ? 8'd1 : reg_max;
  endfunction

  task automatic push_line(input logic [BYTE_W-1:0] b, input logic fe);
    line_beat_t e;
    e.line = b;
    e.frame_end = fe;
    e.last = 1'b0;
    line_exp_q.push_back(e);
  endtask

  task automatic push_stuffed(input logic [BYTE_W-1:0] b);
    if (b == reg_flag || b == reg_esc) begin
      push_line(reg_esc, 1'b0);
      push_line(b ^ ESC_XOR, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endtask

  // msb-first crc, one byte
  task automatic crc_update(input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[CRC_W-1] ? ((c << 1) ^ reg_poly) : (c << 1);
    crc_acc = c;
  endtask

  task automatic send_body(input logic [BYTE_W-1:0] b);
    crc_update(b);
    push_stuffed(b);
  endtask

  task automatic frame_predict(input pkt_beat_t bt);
    logic [BYTE_W-1:0] n;
    line_beat_t tail;
    if (bt.first) begin
      pkt_left  = bt.plen;
      frm_left  = '0;
      frm_idx   = '0;
      dest_hold = bt.dest;
      crc_acc   = '0;
      last_idx  = (bt.plen == '0) ? 8'd0 : (bt.plen - 8'd1) / eff_payload();
    end
    if (pkt_left != '0) begin
      if (frm_left == '0) begin
        n = (pkt_left < eff_payload()) ? pkt_left : eff_payload();
        crc_acc = '0;
        push_line(reg_flag, 1'b0);
        send_body(frm_idx);
        send_body(last_idx);
        send_body(reg_src);
        send_body(dest_hold);
        send_body(n);
        frm_left = n;
      end
      send_body(bt.data);
      frm_left = frm_left - 8'd1;
      pkt_left = pkt_left - 8'd1;
      if (frm_left == '0) begin
        push_stuffed(crc_acc[15:8]);
        push_stuffed(crc_acc[7:0]);
        push_line(reg_flag, 1'b1);
        frm_idx = frm_idx + 8'd1;
        crc_acc = '0;
      end
      tail = line_exp_q.pop_back();
      tail.last = 1'b1;
      line_exp_q.push_back(tail);
    end
  endtask

  // output check first, then prediction for an accepted input beat
  always @(posedge clk) begin : line_check
    line_beat_t want;
    out_fired = rst_n && out_valid && out_ready;
    in_fired  = rst_n && in_valid && in_ready;
    if (out_fired) begin
      if (line_exp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected line beat: expected none, got byte %h end %b last %b",
                 $time, out_line_byte, out_frame_end, out_last_of_run);
      end else begin
        want = line_exp_q.pop_front();
        if (out_line_byte !== want.line) begin
          err_cnt++;
          $display("%0t: line_byte expected %h got %h", $time, want.line, out_line_byte);
        end
        if (out_frame_end !== want.frame_end) begin
          err_cnt++;
          $display("%0t: frame_end expected %b got %b", $time, want.frame_end,
                   out_frame_end);
        end
        if (out_last_of_run !== want.last) begin
          err_cnt++;
          $display("%0t: last_of_run expected %b got %b", $time, want.last,
                   out_last_of_run);
        end
      end
    end
    if (in_fired) begin
      frame_predict(drv_beat);
      beats_taken++;
    end
  end

  always @(negedge clk) begin : sender
    logic vld;
    int   gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      vld = in_valid;
      if (in_valid && in_fired) begin
        vld = 1'b0;
        gap = snd_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (!vld) begin
        if (gap > 0) begin
          gap--;
        end else if (beat_q.size() > 0) begin
          drv_beat = beat_q.pop_front();
          vld = 1'b1;
        end
      end
      in_valid           <= vld;
      in_data_byte       <= drv_beat.data;
      in_packet_length   <= drv_beat.plen;
      in_dest_address    <= drv_beat.dest;
      in_first_of_packet <= drv_beat.first;
    end
  end

  always @(negedge clk) begin : receiver
    int stall_seen;
    int hold_left;
    int rx_gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (long_stall_seq != stall_seen) begin
        stall_seen = long_stall_seq;
        hold_left = 300;
      end
      if (out_fired)
        rx_gap = rcv_idle_en ? $urandom_range(0, 15) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       return reg_flag;
      1:       return reg_esc;
      2:       return reg_flag ^ ESC_XOR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_beat(input logic [BYTE_W-1:0] data, input logic [BYTE_W-1:0] plen,
                          input logic [BYTE_W-1:0] dest, input logic first);
    pkt_beat_t b;
    b.data  = data;
    b.plen  = plen;
    b.dest  = dest;
    b.first = first;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // send the first n_send bytes of a packet of len bytes
  task automatic add_packet(input int len, input logic [BYTE_W-1:0] dst, input int n_send);
    for (int i = 0; i < n_send; i++) begin
      if (i == 0)
        add_beat(pick_data(), len[7:0], dst, 1'b1);
      else
        add_beat(pick_data(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SOURCE_ADDRESS: reg_src  = val[7:0];
      CFG_MAX_PAYLOAD:    reg_max  = val[7:0];
      CFG_CRC_POLYNOMIAL: reg_poly = val;
      CFG_FLAG_BYTE:      reg_flag = val[7:0];
      CFG_ESCAPE_BYTE:    reg_esc  = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [7:0] src, input logic [7:0] maxp,
                           input logic [15:0] poly, input logic [7:0] flag,
                           input logic [7:0] esc);
    reg_write(CFG_SOURCE_ADDRESS, {8'h00, src});
    reg_write(CFG_MAX_PAYLOAD, {8'h00, maxp});
    reg_write(CFG_CRC_POLYNOMIAL, poly);
    reg_write(CFG_FLAG_BYTE, {8'h00, flag});
    reg_write(CFG_ESCAPE_BYTE, {8'h00, esc});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every beat is taken and every line byte is back, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (beats_taken != beats_queued || line_exp_q.size() != 0);
    repeat (100) @(negedge clk);
  endtask

  initial begin : stimulus
    int               ph;
    int               len;
    int               n;
    int               r;
    int               phase_beats;
    int               rand_beats;
    logic [BYTE_W-1:0] maxp;
    logic [BYTE_W-1:0] flag;
    logic [CRC_W-1:0]  poly;
    rand_beats = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values
    add_beat(8'h00, 8'd1, 8'h00, 1'b1);
    add_beat(8'h7e, 8'd3, 8'hff, 1'b1);
    add_beat(8'h7d, 8'h00, 8'h00, 1'b0);
    add_beat(8'hff, 8'hff, 8'hff, 1'b0);
    add_beat(8'ha5, 8'hff, 8'hff, 1'b0);   // stray byte, no packet open
    add_beat(8'h5a, 8'd0, 8'h12, 1'b1);    // empty packet
    add_beat(8'h7e, 8'd255, 8'h80, 1'b1);  // abandoned after two bytes
    add_beat(8'h01, 8'h00, 8'h00, 1'b0);
    add_beat(8'h20, 8'd2, 8'h01, 1'b1);
    add_beat(8'h5e, 8'h00, 8'h00, 1'b0);
    settle();

    load_regs(8'hff, 8'd1, 16'hffff, 8'h00, 8'hff);
    @(posedge clk);
    add_beat(8'hff, 8'd3, 8'h7e, 1'b1);
    add_beat(8'h00, 8'h00, 8'h00, 1'b0);
    add_beat(8'h20, 8'h00, 8'h00, 1'b0);
    settle();

    // zero payload limit, flag equal to escape
    load_regs(8'h55, 8'd0, 16'h0000, 8'h55, 8'h55);
    @(posedge clk);
    add_beat(8'h55, 8'd2, 8'h55, 1'b1);
    add_beat(8'h75, 8'h00, 8'h00, 1'b0);
    settle();

    // registers change part way through a packet
    load_regs(8'h00, 8'd3, RST_CRC_POLYNOMIAL, RST_FLAG_BYTE, RST_ESCAPE_BYTE);
    @(posedge clk);
    add_packet(7, 8'h3c, 4);
    settle();
    load_regs(8'ha5, 8'd1, RST_CRC_POLYNOMIAL, RST_FLAG_BYTE, RST_ESCAPE_BYTE);
    @(posedge clk);
    for (int i = 0; i < 3; i++)
      add_beat(pick_data(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);

    for (ph = 0; rand_beats < 80 || ph < 3; ph++) begin
      settle();
      case (ph % 4)
        1:       maxp = 8'd1;
        2:       maxp = 8'd255;
        default: maxp = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       poly = 16'h0000;
        1:       poly = 16'hffff;
        2:       poly = RST_CRC_POLYNOMIAL;
        default: poly = 16'($urandom_range(0, 65535));
      endcase
      flag = 8'($urandom_range(0, 255));
      load_regs(8'($urandom_range(0, 255)), maxp, poly, flag,
                ($urandom_range(0, 5) == 0) ? flag : 8'($urandom_range(0, 255)));
      @(posedge clk);
      snd_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
      rcv_idle_en = (ph != 0) && ($urandom_range(0, 3) != 0);
      phase_beats = 0;
      if (ph == 2) begin
        // receiver stalls for a long stretch while a long packet queues up
        long_stall_seq++;
        add_packet(20, 8'($urandom_range(0, 255)), 20);
        phase_beats += 20;
      end
      while (phase_beats < 20) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          add_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0);
        end else if (r == 1) begin
          add_beat(8'($urandom_range(0, 255)), 8'd0, 8'($urandom_range(0, 255)), 1'b1);
        end else if (r <= 3) begin
          n = $urandom_range(1, 6);
          add_packet($urandom_range(n + 1, 255), 8'($urandom_range(0, 255)), n);
          phase_beats += n;
        end else begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          add_packet(len, 8'($urandom_range(0, 255)), len);
          phase_beats += len;
        end
      end
      rand_beats += phase_beats;
    end
    settle();

    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
